>>> design/qdds_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature DDS package
// Shared types, constants and the quarter-wave sine table of the oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package qdds_pkg;

  localparam int PhaseBitsDefault     = 32;
  localparam int TableAddrBitsDefault = 10;
  localparam int BufferPairsDefault   = 1024;
  localparam int BlockPairsDefault    = 512;

  localparam int RomBits     = 10;
  localparam int QuarterBits = 9;
  localparam int MagBits     = 15;
  localparam int SampleBits  = 16;
  localparam int IndexBits   = 10;

  localparam logic [16:0] TuneStep  = 17'd85900;
  localparam logic [15:0] FreqMin   = 16'd20;
  localparam logic [15:0] FreqMax   = 16'd40000;
  localparam logic [15:0] FreqReset = 16'd1000;

  typedef struct packed {
    logic signed [SampleBits-1:0] adc_left;
    logic signed [SampleBits-1:0] adc_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] dac_sample;
    logic signed [SampleBits-1:0] left_capture;
    logic signed [SampleBits-1:0] right_capture;
    logic signed [SampleBits-1:0] sine_ref;
    logic signed [SampleBits-1:0] quadrature_ref;
    logic        [IndexBits-1:0]  sample_index;
    logic                         block_last;
  } out_word_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sine;
    logic signed [SampleBits-1:0] cosine;
  } lut_resp_t;

  localparam logic [MagBits-1:0] QuarterWave [257] = '{
    15'd0, 15'd184, 15'd368, 15'd552, 15'd736, 15'd920, 15'd1104, 15'd1288,
    15'd1472, 15'd1656, 15'd1840, 15'd2023, 15'd2207, 15'd2390, 15'd2574,
    15'd2757, 15'd2941, 15'd3124, 15'd3307, 15'd3490, 15'd3672, 15'd3855,
    15'd4037, 15'd4220, 15'd4402, 15'd4584, 15'd4766, 15'd4947, 15'd5129,
    15'd5310, 15'd5491, 15'd5672, 15'd5853, 15'd6033, 15'd6213, 15'd6393,
    15'd6573, 15'd6753, 15'd6932, 15'd7111, 15'd7289, 15'd7468, 15'd7646,
    15'd7824, 15'd8001, 15'd8179, 15'd8356, 15'd8532, 15'd8709, 15'd8885,
    15'd9060, 15'd9235, 15'd9410, 15'd9585, 15'd9759, 15'd9933, 15'd10107,
    15'd10280, 15'd10453, 15'd10625, 15'd10797, 15'd10968, 15'd11140,
    15'd11310, 15'd11481, 15'd11650, 15'd11820, 15'd11989, 15'd12157,
    15'd12325, 15'd12493, 15'd12660, 15'd12827, 15'd12993, 15'd13158,
    15'd13324, 15'd13488, 15'd13653, 15'd13816, 15'd13979, 15'd14142,
    15'd14304, 15'd14466, 15'd14627, 15'd14787, 15'd14947, 15'd15106,
    15'd15265, 15'd15423, 15'd15581, 15'd15738, 15'd15894, 15'd16050,
    15'd16205, 15'd16360, 15'd16514, 15'd16667, 15'd16820, 15'd16972,
    15'd17123, 15'd17274, 15'd17424, 15'd17574, 15'd17723, 15'd17871,
    15'd18018, 15'd18165, 15'd18311, 15'd18457, 15'd18602, 15'd18746,
    15'd18889, 15'd19032, 15'd19174, 15'd19315, 15'd19455, 15'd19595,
    15'd19734, 15'd19872, 15'd20010, 15'd20147, 15'd20283, 15'd20418,
    15'd20553, 15'd20686, 15'd20819, 15'd20951, 15'd21083, 15'd21213,
    15'd21343, 15'd21472, 15'd21600, 15'd21727, 15'd21854, 15'd21980,
    15'd22104, 15'd22229, 15'd22352, 15'd22474, 15'd22596, 15'd22716,
    15'd22836, 15'd22955, 15'd23073, 15'd23190, 15'd23307, 15'd23422,
    15'd23537, 15'd23650, 15'd23763, 15'd23875, 15'd23986, 15'd24096,
    15'd24205, 15'd24314, 15'd24421, 15'd24528, 15'd24633, 15'd24738,
    15'd24841, 15'd24944, 15'd25046, 15'd25147, 15'd25247, 15'd25346,
    15'd25444, 15'd25541, 15'd25637, 15'd25732, 15'd25826, 15'd25919,
    15'd26011, 15'd26103, 15'd26193, 15'd26282, 15'd26370, 15'd26458,
    15'd26544, 15'd26629, 15'd26713, 15'd26797, 15'd26879, 15'd26960,
    15'd27040, 15'd27120, 15'd27198, 15'd27275, 15'd27351, 15'd27426,
    15'd27500, 15'd27573, 15'd27645, 15'd27716, 15'd27786, 15'd27855,
    15'd27923, 15'd27990, 15'd28056, 15'd28120, 15'd28184, 15'd28246,
    15'd28308, 15'd28368, 15'd28428, 15'd28486, 15'd28543, 15'd28599,
    15'd28654, 15'd28708, 15'd28761, 15'd28813, 15'd28864, 15'd28913,
    15'd28962, 15'd29009, 15'd29056, 15'd29101, 15'd29145, 15'd29188,
    15'd29230, 15'd29271, 15'd29311, 15'd29350, 15'd29387, 15'd29424,
    15'd29459, 15'd29493, 15'd29526, 15'd29558, 15'd29589, 15'd29619,
    15'd29648, 15'd29675, 15'd29702, 15'd29727, 15'd29751, 15'd29774,
    15'd29796, 15'd29817, 15'd29837, 15'd29856, 15'd29873, 15'd29889,
    15'd29905, 15'd29919, 15'd29932, 15'd29944, 15'd29954, 15'd29964,
    15'd29972, 15'd29980, 15'd29986, 15'd29991, 15'd29995, 15'd29998,
    15'd29999, 15'd30000
  };

endpackage

`default_nettype wire

>>> design/qdds_lut.sv
// ----------------------------------------------------------------------------
// Quadrature DDS sine lookup
// Registered two-port read of the quarter-wave ROM for the in-phase and
// quadrature phase indexes; the index is folded before the read, the sign after.
// ----------------------------------------------------------------------------
`default_nettype none

module qdds_lut #(
  parameter int TABLE_ADDR_BITS = qdds_pkg::TableAddrBitsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [TABLE_ADDR_BITS-1:0] addr_i,
  output qdds_pkg::lut_resp_t             resp_o
);

  localparam logic [TABLE_ADDR_BITS-1:0] QuadOffset =
    TABLE_ADDR_BITS'(3) << (TABLE_ADDR_BITS - 2);

  logic [TABLE_ADDR_BITS-1:0] qaddr;
  logic [qdds_pkg::RomBits-1:0] sin_k;
  logic [qdds_pkg::RomBits-1:0] cos_k;
  logic [qdds_pkg::QuarterBits-1:0] sin_idx;
  logic [qdds_pkg::QuarterBits-1:0] cos_idx;

  logic [qdds_pkg::MagBits-1:0] sin_mag_q;
  logic [qdds_pkg::MagBits-1:0] cos_mag_q;
  logic sin_neg_q;
  logic cos_neg_q;

  assign qaddr = addr_i + QuadOffset;

  if (TABLE_ADDR_BITS >= qdds_pkg::RomBits) begin : g_drop
    assign sin_k = addr_i[TABLE_ADDR_BITS-1 -: qdds_pkg::RomBits];
    assign cos_k = qaddr[TABLE_ADDR_BITS-1 -: qdds_pkg::RomBits];
  end else begin : g_fill
    assign sin_k = {addr_i, {(qdds_pkg::RomBits - TABLE_ADDR_BITS){1'b0}}};
    assign cos_k = {qaddr, {(qdds_pkg::RomBits - TABLE_ADDR_BITS){1'b0}}};
  end

  always_comb begin
    sin_idx = sin_k[8] ? (9'd256 - {1'b0, sin_k[7:0]}) : {1'b0, sin_k[7:0]};
    cos_idx = cos_k[8] ? (9'd256 - {1'b0, cos_k[7:0]}) : {1'b0, cos_k[7:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_mag_q <= qdds_pkg::QuarterWave[sin_idx];
      cos_mag_q <= qdds_pkg::QuarterWave[cos_idx];
      sin_neg_q <= sin_k[9];
      cos_neg_q <= cos_k[9];
    end
  end

  always_comb begin
    resp_o.sine   = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
    resp_o.cosine = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});
  end

endmodule

`default_nettype wire

>>> design/quadrature_dds_with_capture_unit.sv
// ----------------------------------------------------------------------------
// Quadrature DDS with capture
// Numerically controlled oscillator with sine and quadrature references and
// stereo ADC sample pass-through with capture buffer position marking.
// ----------------------------------------------------------------------------
// Usage: each input word carries one stereo ADC sample pair. For every word
// accepted, exactly one output word is produced holding the DAC sine sample,
// the in-phase and quadrature references, both captured samples, the pair's
// position in the capture buffer and a flag for the end of each block.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The configuration channel writes the output frequency in
// hertz (clamped to 20..40000) with valid and ready; ready is always high.
// There are two register stages: an accepted word is held in the lookup
// stage beside the registered sine ROM read, then in the output register.
// One word is accepted per cycle while the receiver does not stall: the phase
// accumulator add and the registered sine ROM read are pipelined. When the
// receiver stalls, the output word holds and the lookup stage fills; input
// stall rises only when both stages are full and the receiver stalls. Reset
// clears the phase, the pair counter and the pipeline and sets the frequency
// to 1000 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_dds_with_capture_unit #(
  parameter int PHASE_BITS      = qdds_pkg::PhaseBitsDefault,
  parameter int TABLE_ADDR_BITS = qdds_pkg::TableAddrBitsDefault,
  parameter int BUFFER_PAIRS    = qdds_pkg::BufferPairsDefault,
  parameter int BLOCK_PAIRS     = qdds_pkg::BlockPairsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [15:0]   cfg_frequency_hz_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire qdds_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output qdds_pkg::out_word_t out_word_o
);

  localparam int CntW  = $clog2(BUFFER_PAIRS);
  localparam int BlkW  = $clog2(BLOCK_PAIRS);
  localparam int ProdW = PHASE_BITS + 34;
  localparam logic [CntW-1:0] CntLast = CntW'(BUFFER_PAIRS - 1);
  localparam logic [BlkW-1:0] BlkLast = BlkW'(BLOCK_PAIRS - 1);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] tune_q, tune_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [BlkW-1:0]       blk_q, blk_d;

  logic                  s1_valid_q, s1_valid_d;
  qdds_pkg::in_word_t    s1_in_q;
  logic [CntW-1:0]       s1_pos_q;
  logic                  s1_last_q;

  logic                  out_valid_q, out_valid_d;
  qdds_pkg::out_word_t   out_q;

  logic                  s2_en;
  logic                  s1_en;
  logic                  accept;
  logic [15:0]           freq_clamped;
  logic [ProdW-1:0]      tune_prod;
  qdds_pkg::lut_resp_t   lut_resp;

  assign cfg_ready_o = 1'b1;

  assign s2_en      = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;
  assign accept     = in_valid_i && s1_en;

  always_comb begin
    if (cfg_frequency_hz_i > qdds_pkg::FreqMax) begin
      freq_clamped = qdds_pkg::FreqMax;
    end else if (cfg_frequency_hz_i < qdds_pkg::FreqMin) begin
      freq_clamped = qdds_pkg::FreqMin;
    end else begin
      freq_clamped = cfg_frequency_hz_i;
    end
    tune_prod = ProdW'(freq_clamped) * ProdW'(qdds_pkg::TuneStep);
    tune_d    = (cfg_valid_i && cfg_ready_o) ? tune_prod[PHASE_BITS-1:0] : tune_q;
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    blk_d      = blk_q;
    s1_valid_d = s1_valid_q;
    if (accept) begin
      phase_d = phase_q + tune_q;
      if (pos_q == CntLast) begin
        pos_d = '0;
        blk_d = '0;
      end else begin
        pos_d = pos_q + CntW'(1);
        blk_d = (blk_q == BlkLast) ? '0 : blk_q + BlkW'(1);
      end
    end
    if (s1_en) begin
      s1_valid_d = accept;
    end
  end

  assign out_valid_d = s2_en ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tune_q      <= PHASE_BITS'(ProdW'(qdds_pkg::FreqReset) * ProdW'(qdds_pkg::TuneStep));
      pos_q       <= '0;
      blk_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tune_q      <= tune_d;
      pos_q       <= pos_d;
      blk_q       <= blk_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_q   <= in_word_i;
      s1_pos_q  <= pos_q;
      s1_last_q <= (blk_q == BlkLast);
    end
  end

  qdds_lut #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_lut (
    .clk_i (clk_i),
    .en_i  (accept),
    .addr_i(phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .resp_o(lut_resp)
  );

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      out_q.dac_sample     <= lut_resp.sine;
      out_q.left_capture   <= s1_in_q.adc_left;
      out_q.right_capture  <= s1_in_q.adc_right;
      out_q.sine_ref       <= lut_resp.sine;
      out_q.quadrature_ref <= lut_resp.cosine;
      out_q.sample_index   <= qdds_pkg::IndexBits'(s1_pos_q);
      out_q.block_last     <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> phase_q == $past(phase_q + tune_q))
    else $error("phase accumulator did not advance by the tuning word");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pos_q == (($past(pos_q) == CntLast) ? '0 : $past(pos_q) + CntW'(1)))
    else $error("pair counter stepped wrongly");

  a_sine_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.dac_sample == out_word_o.sine_ref)
    else $error("DAC sample differs from in-phase reference");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_en) |=> s1_valid_q)
    else $error("lookup stage word lost while output stalled");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Quadrature DDS with capture testbench
// Sends stereo ADC pairs through the oscillator and checks each output word
// against a cycle-free predictor of phase, sine table, counter and flags.
// Sender gaps, receiver stalls and a long receiver hold-off are exercised
// across several output frequencies, clamped extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [9:0] QuadOffset = 10'd768;
  localparam int         RoundItems = 120;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [15:0] cfg_hz = 16'd0;
  logic      adc_valid = 1'b0;
  logic      in_stall;
  qdds_pkg::in_word_t  adc_word = '0;
  logic      dds_valid;
  logic      out_stall = 1'b0;
  qdds_pkg::out_word_t dds_word;

  logic [31:0] tone_phase = 32'd0;
  logic [9:0]  pair_count = 10'd0;
  logic [15:0] tone_freq_hz = qdds_pkg::FreqReset;

  qdds_pkg::out_word_t pending_words[$];
  int        errors = 0;

  bit tx_idle_on = 1'b0;
  int burst_left = 0;
  bit rx_stall_on = 1'b0;
  bit rx_stalled = 1'b0;
  int rx_left = 0;
  int hold_req = 0;
  int hold_left = 0;

  quadrature_dds_with_capture_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_frequency_hz_i (cfg_hz),
    .in_valid_i         (adc_valid),
    .in_stall_o         (in_stall),
    .in_word_i          (adc_word),
    .out_valid_o        (dds_valid),
    .out_stall_i        (out_stall),
    .out_word_o         (dds_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] sine_at(input logic [9:0] k);
    logic [8:0]  off;
    logic [15:0] mag;
    off = {1'b0, k[7:0]};
    mag = {1'b0, (k[8] ? qdds_pkg::QuarterWave[9'd256 - off] : qdds_pkg::QuarterWave[off])};
    return k[9] ? 16'(16'd0 - mag) : mag;
  endfunction

  function automatic qdds_pkg::out_word_t next_dds_word(input qdds_pkg::in_word_t w);
    qdds_pkg::out_word_t r;
    logic [9:0]  idx;
    logic [31:0] hz;
    idx = tone_phase[31:22];
    hz = {16'd0, tone_freq_hz};
    if (hz > {16'd0, qdds_pkg::FreqMax}) hz = {16'd0, qdds_pkg::FreqMax};
    if (hz < {16'd0, qdds_pkg::FreqMin}) hz = {16'd0, qdds_pkg::FreqMin};
    r.dac_sample     = sine_at(idx);
    r.left_capture   = w.adc_left;
    r.right_capture  = w.adc_right;
    r.sine_ref       = sine_at(idx);
    r.quadrature_ref = sine_at(idx + QuadOffset);
    r.sample_index   = pair_count;
    r.block_last     = (pair_count[8:0] == 9'h1ff);
    tone_phase = tone_phase + 32'(hz * {15'd0, qdds_pkg::TuneStep});
    pair_count = pair_count + 10'd1;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    qdds_pkg::out_word_t want;
    if (dds_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, dds_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("dac_sample", want.dac_sample, dds_word.dac_sample);
        check_field("left_capture", want.left_capture, dds_word.left_capture);
        check_field("right_capture", want.right_capture, dds_word.right_capture);
        check_field("sine_ref", want.sine_ref, dds_word.sine_ref);
        check_field("quadrature_ref", want.quadrature_ref, dds_word.quadrature_ref);
        check_field("sample_index", want.sample_index, dds_word.sample_index);
        check_field("block_last", want.block_last, dds_word.block_last);
      end
    end
  end

  // A long hold-off request takes priority over the random stall pattern.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!rx_stall_on) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_stalled = !rx_stalled;
        rx_left = rx_stalled ? $urandom_range(1, 5) : $urandom_range(1, 12);
      end
      rx_left--;
      out_stall <= rx_stalled;
    end
  end

  task automatic send_pair(input qdds_pkg::in_word_t w);
    if (tx_idle_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk_i);
        adc_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk_i);
    adc_valid <= 1'b1;
    adc_word <= w;
    do @(posedge clk_i); while (in_stall);
    pending_words.push_back(next_dds_word(w));
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    adc_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frequency(input logic [15:0] hz);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_hz <= hz;
    do @(posedge clk_i); while (!cfg_ready);
    tone_freq_hz = hz;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_sample_extremes();
    qdds_pkg::in_word_t w;
    logic [15:0] lefts [6];
    logic [15:0] rights [6];
    lefts = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
    rights = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'hfffe, 16'haaaa};
    for (int i = 0; i < 6; i++) begin
      w.adc_left = lefts[i];
      w.adc_right = rights[i];
      send_pair(w);
    end
    wait_idle();
  endtask

  task automatic test_frequency_clamp();
    qdds_pkg::in_word_t w;
    logic [15:0] rates [6];
    rates = '{16'd0, 16'd19, 16'd20, 16'd40000, 16'd40001, 16'd65535};
    for (int i = 0; i < 6; i++) begin
      write_frequency(rates[i]);
      repeat (3) begin
        w.adc_left = random_sample();
        w.adc_right = random_sample();
        send_pair(w);
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    qdds_pkg::in_word_t w;
    write_frequency(16'd12345);
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    hold_req = 60;
    repeat (80) begin
      w.adc_left = random_sample();
      w.adc_right = random_sample();
      send_pair(w);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    qdds_pkg::in_word_t w;
    logic [15:0] hz;
    for (int round = 0; round < 8; round++) begin
      case ($urandom_range(0, 3))
        0: hz = 16'($urandom_range(0, 25));
        1: hz = 16'($urandom_range(39990, 40010));
        2: hz = 16'($urandom_range(20, 40000));
        default: hz = 16'($urandom_range(0, 65535));
      endcase
      write_frequency(hz);
      tx_idle_on = (round != 0) && (round != 2);
      rx_stall_on = (round != 0) && (round != 1);
      repeat (RoundItems) begin
        w.adc_left = random_sample();
        w.adc_right = random_sample();
        send_pair(w);
      end
      wait_idle();
    end
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    test_sample_extremes();
    test_frequency_clamp();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> quadrature_dds_with_capture_unit.f
design/qdds_pkg.sv
design/qdds_lut.sv
design/quadrature_dds_with_capture_unit.sv
tb/sv/testbench.sv
